// File: hw/rtl/pdb_pkg.sv
// Shared widths and blend mode codes for the Porter-Duff pixel blend unit.
package pdb_pkg;

    localparam int PIX_W  = 8;
    localparam int MODE_W = 4;

    localparam logic [MODE_W-1:0] MODE_CLEAR   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SRC     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_DST     = 4'd2;
    localparam logic [MODE_W-1:0] MODE_SRCOVER = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DSTOVER = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SRCIN   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_DSTIN   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SRCOUT  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_DSTOUT  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_SRCATOP = 4'd9;
    localparam logic [MODE_W-1:0] MODE_DSTATOP = 4'd10;
    localparam logic [MODE_W-1:0] MODE_XOR     = 4'd11;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [MODE_W-1:0] mode_t;

endpackage

// File: hw/rtl/pdb_channel.sv
// One channel of the Porter-Duff blend: operand select, two products, divide by 255, saturate.
module pdb_channel
(
    input  pdb_pkg::mode_t mode,
    input  logic           is_alpha,
    input  pdb_pkg::pix_t  sa,
    input  pdb_pkg::pix_t  da,
    input  pdb_pkg::pix_t  sc,
    input  pdb_pkg::pix_t  dc,
    output pdb_pkg::pix_t  res
);

    pdb_pkg::pix_t nsa;
    pdb_pkg::pix_t nda;
    pdb_pkg::pix_t m0;
    pdb_pkg::pix_t n0;
    pdb_pkg::pix_t m1;
    pdb_pkg::pix_t n1;
    logic [8:0]    base;
    logic          sub;
    logic [15:0]   prod0;
    logic [15:0]   prod1;
    logic [16:0]   prod_sum;
    logic [17:0]   rnd;
    logic [17:0]   rnd_sum;
    logic [9:0]    quo;
    logic [10:0]   total;

    assign nsa = 8'hFF - sa;
    assign nda = 8'hFF - da;

    always_comb
    begin
        m0   = '0;
        n0   = '0;
        m1   = '0;
        n1   = '0;
        base = '0;
        sub  = 1'b0;
        unique case (mode)
            pdb_pkg::MODE_SRC:
            begin
                base = {1'b0, sc};
            end
            pdb_pkg::MODE_DST:
            begin
                base = {1'b0, dc};
            end
            pdb_pkg::MODE_SRCOVER:
            begin
                base = {1'b0, sc};
                m0   = nsa;
                n0   = dc;
            end
            pdb_pkg::MODE_DSTOVER:
            begin
                base = {1'b0, dc};
                m0   = nda;
                n0   = sc;
            end
            pdb_pkg::MODE_SRCIN:
            begin
                m0 = sc;
                n0 = da;
            end
            pdb_pkg::MODE_DSTIN:
            begin
                m0 = dc;
                n0 = sa;
            end
            pdb_pkg::MODE_SRCOUT:
            begin
                m0 = sc;
                n0 = nda;
            end
            pdb_pkg::MODE_DSTOUT:
            begin
                m0 = dc;
                n0 = nsa;
            end
            pdb_pkg::MODE_SRCATOP:
            begin
                if (is_alpha)
                begin
                    base = {1'b0, da};
                end
                else
                begin
                    m0 = sc;
                    n0 = da;
                    m1 = dc;
                    n1 = nsa;
                end
            end
            pdb_pkg::MODE_DSTATOP:
            begin
                if (is_alpha)
                begin
                    base = {1'b0, sa};
                end
                else
                begin
                    m0 = dc;
                    n0 = sa;
                    m1 = sc;
                    n1 = nda;
                end
            end
            pdb_pkg::MODE_XOR:
            begin
                if (is_alpha)
                begin
                    // sa + da - div255(2*sa*da)
                    base = {1'b0, sa} + {1'b0, da};
                    sub  = 1'b1;
                    m0   = sa;
                    n0   = da;
                    m1   = sa;
                    n1   = da;
                end
                else
                begin
                    m0 = sc;
                    n0 = nda;
                    m1 = dc;
                    n1 = nsa;
                end
            end
            default:
            begin
                base = '0;
            end
        endcase
    end

    assign prod0    = m0 * n0;
    assign prod1    = m1 * n1;
    assign prod_sum = {1'b0, prod0} + {1'b0, prod1};
    assign rnd      = {1'b0, prod_sum} + 18'd128;
    assign rnd_sum  = rnd + (rnd >> 8);
    assign quo      = rnd_sum[17:8];

    always_comb
    begin
        if (sub)
        begin
            total = (quo > {1'b0, base}) ? 11'd0 : ({2'b00, base} - {1'b0, quo});
        end
        else
        begin
            total = {2'b00, base} + {1'b0, quo};
        end
    end

    assign res = (|total[10:8]) ? 8'hFF : total[7:0];

endmodule

// File: hw/rtl/porter_duff_pixel_blend_unit.sv
// Top level of the Porter-Duff pixel blend unit: input stage, blend lanes, result stage.
//
// Usage:
//   Input channel in_valid/in_ready carries one word: a premultiplied ARGB8888
//   source pixel (src_a/r/g/b) and destination pixel (dst_a/r/g/b).
//   Output channel out_valid/out_ready carries the blended pixel out_a/r/g/b.
//   cfg_wr_en/cfg_wr_data write the 4-bit blend mode (0 clear .. 11 xor,
//   12 to 15 act as clear); write it only while no word is in flight.
// Timing:
//   An accepted word passes the input register, then the result register,
//   before it is shown. One word is accepted every cycle while out_ready
//   stays high; the rate is set by the input register feeding the four blend
//   lanes and the result register, each advancing once per cycle if not stalled.
// Reset:
//   rst_n clears both stage valids and sets the mode to src-over.
// Stall:
//   When out_ready is low the result word holds; one more word waits in the
//   input stage, then in_ready drops until the result is taken.
module porter_duff_pixel_blend_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  pdb_pkg::mode_t        cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pdb_pkg::pix_t         src_a,
    input  pdb_pkg::pix_t         src_r,
    input  pdb_pkg::pix_t         src_g,
    input  pdb_pkg::pix_t         src_b,
    input  pdb_pkg::pix_t         dst_a,
    input  pdb_pkg::pix_t         dst_r,
    input  pdb_pkg::pix_t         dst_g,
    input  pdb_pkg::pix_t         dst_b,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pdb_pkg::pix_t         out_a,
    output pdb_pkg::pix_t         out_r,
    output pdb_pkg::pix_t         out_g,
    output pdb_pkg::pix_t         out_b
);

    pdb_pkg::mode_t mode_reg;
    logic           in_valid_reg;
    logic           in_valid_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           in_take;
    logic           out_adv;
    pdb_pkg::pix_t  src_reg [4];
    pdb_pkg::pix_t  dst_reg [4];
    pdb_pkg::pix_t  res_next [4];
    pdb_pkg::pix_t  res_reg [4];

    assign out_adv  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || out_adv;
    assign in_take  = in_valid && in_ready;

    assign in_valid_next  = in_take || (in_valid_reg && !out_adv);
    assign out_valid_next = out_adv ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= pdb_pkg::MODE_SRCOVER;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the input word.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            src_reg[0] <= src_a;
            src_reg[1] <= src_r;
            src_reg[2] <= src_g;
            src_reg[3] <= src_b;
            dst_reg[0] <= dst_a;
            dst_reg[1] <= dst_r;
            dst_reg[2] <= dst_g;
            dst_reg[3] <= dst_b;
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        pdb_channel u_channel
        (
            .mode     (mode_reg),
            .is_alpha (i == 0),
            .sa       (src_reg[0]),
            .da       (dst_reg[0]),
            .sc       (src_reg[i]),
            .dc       (dst_reg[i]),
            .res      (res_next[i])
        );
    end

    // Advance the result word.
    always_ff @(posedge clk)
    begin
        if (out_adv && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_a     = res_reg[0];
    assign out_r     = res_reg[1];
    assign out_g     = res_reg[2];
    assign out_b     = res_reg[3];

endmodule

// File: hw/rtl/pdb_check.sv
// Port-level checker for the Porter-Duff pixel blend unit, bound to the top level.
module pdb_check
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input pdb_pkg::pix_t out_a,
    input pdb_pkg::pix_t out_r,
    input pdb_pkg::pix_t out_g,
    input pdb_pkg::pix_t out_b
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_a) && $stable(out_r)
            && $stable(out_g) && $stable(out_b))
        else $error("result word changed while stalled");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("accepted word not shown two cycles later");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output stage is empty");

endmodule

bind porter_duff_pixel_blend_unit pdb_check u_pdb_check (.*);

// File: dv/pdb_blend_checker.sv
// Checker for the Porter-Duff pixel blend unit: predicts each blended pixel and compares it.
module pdb_blend_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  pdb_pkg::mode_t cfg_wr_data,
    input  logic           in_valid,
    input  logic           in_ready,
    input  pdb_pkg::pix_t  src_a,
    input  pdb_pkg::pix_t  src_r,
    input  pdb_pkg::pix_t  src_g,
    input  pdb_pkg::pix_t  src_b,
    input  pdb_pkg::pix_t  dst_a,
    input  pdb_pkg::pix_t  dst_r,
    input  pdb_pkg::pix_t  dst_g,
    input  pdb_pkg::pix_t  dst_b,
    input  logic           out_valid,
    input  logic           out_ready,
    input  pdb_pkg::pix_t  out_a,
    input  pdb_pkg::pix_t  out_r,
    input  pdb_pkg::pix_t  out_g,
    input  pdb_pkg::pix_t  out_b,
    output int             mismatches,
    output int             blends_waiting,
    output int             words_checked,
    output int             input_stalls
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CHAN_MAX = 255;
    localparam int unsigned ROUND_BIAS = 128;

    typedef struct packed {
        pdb_pkg::pix_t a;
        pdb_pkg::pix_t r;
        pdb_pkg::pix_t g;
        pdb_pkg::pix_t b;
    } argb_t;

    pdb_pkg::mode_t active_mode = pdb_pkg::MODE_SRCOVER;
    argb_t expected_pixels[$];

    function automatic int unsigned div_by_255(int unsigned x);
        int unsigned t;
        t = x + ROUND_BIAS;
        return (t + (t >> 8)) >> 8;
    endfunction

    function automatic argb_t blend_pixel(pdb_pkg::mode_t m, argb_t s, argb_t d);
        int unsigned sc[4];
        int unsigned dc[4];
        pdb_pkg::pix_t res[4];
        int unsigned sa;
        int unsigned da;
        int unsigned nsa;
        int unsigned nda;
        int unsigned v;
        int unsigned sum;
        int unsigned sub;
        argb_t o;
        sc = '{32'(s.a), 32'(s.r), 32'(s.g), 32'(s.b)};
        dc = '{32'(d.a), 32'(d.r), 32'(d.g), 32'(d.b)};
        sa = sc[0];
        da = dc[0];
        nsa = CHAN_MAX - sa;
        nda = CHAN_MAX - da;
        for (int i = 0; i < 4; i++)
        begin
            case (m)
                pdb_pkg::MODE_SRC:     v = sc[i];
                pdb_pkg::MODE_DST:     v = dc[i];
                pdb_pkg::MODE_SRCOVER: v = sc[i] + div_by_255(nsa * dc[i]);
                pdb_pkg::MODE_DSTOVER: v = dc[i] + div_by_255(nda * sc[i]);
                pdb_pkg::MODE_SRCIN:   v = div_by_255(sc[i] * da);
                pdb_pkg::MODE_DSTIN:   v = div_by_255(dc[i] * sa);
                pdb_pkg::MODE_SRCOUT:  v = div_by_255(sc[i] * nda);
                pdb_pkg::MODE_DSTOUT:  v = div_by_255(dc[i] * nsa);
                pdb_pkg::MODE_SRCATOP:
                    v = (i == 0) ? da : div_by_255(sc[i] * da + dc[i] * nsa);
                pdb_pkg::MODE_DSTATOP:
                    v = (i == 0) ? sa : div_by_255(dc[i] * sa + sc[i] * nda);
                pdb_pkg::MODE_XOR:
                begin
                    if (i == 0)
                    begin
                        sum = sa + da;
                        sub = div_by_255(2 * sa * da);
                        v = (sub > sum) ? 0 : sum - sub;
                    end
                    else
                    begin
                        v = div_by_255(sc[i] * nda + dc[i] * nsa);
                    end
                end
                default:      v = 0;
            endcase
            res[i] = (v > CHAN_MAX) ? 8'(CHAN_MAX) : 8'(v);
        end
        o.a = res[0];
        o.r = res[1];
        o.g = res[2];
        o.b = res[3];
        return o;
    endfunction

    task automatic check_channel(string name, pdb_pkg::pix_t want, pdb_pkg::pix_t got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        argb_t want;
        if (!rst_n)
        begin
            active_mode = pdb_pkg::MODE_SRCOVER;
            expected_pixels.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_pixels = {expected_pixels, blend_pixel(active_mode,
                    '{src_a, src_r, src_g, src_b}, '{dst_a, dst_r, dst_g, dst_b})};
            if (in_valid && !in_ready)
                input_stalls++;
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t ns: unexpected word, expected none actual %0d/%0d/%0d/%0d",
                             $time, out_a, out_r, out_g, out_b);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_channel("out_a", want.a, out_a);
                    check_channel("out_r", want.r, out_r);
                    check_channel("out_g", want.g, out_g);
                    check_channel("out_b", want.b, out_b);
                    words_checked++;
                end
            end
            if (cfg_wr_en)
                active_mode = cfg_wr_data;
        end
        blends_waiting = expected_pixels.size();
    end

endmodule

// File: dv/tb_porter_duff_pixel_blend_unit.sv
// Testbench top for the Porter-Duff pixel blend unit: stimulus, backpressure and verdict.
module tb_porter_duff_pixel_blend_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIXEL_TARGET = 1450;
    localparam int CORNER_COUNT = 8;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AT = 300;
    localparam int STEADY_FROM = 700;
    localparam int STEADY_TO = 900;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT = 5000;
    localparam int MODE_CODES = 1 << pdb_pkg::MODE_W;

    typedef struct packed {
        pdb_pkg::pix_t a;
        pdb_pkg::pix_t r;
        pdb_pkg::pix_t g;
        pdb_pkg::pix_t b;
    } argb_t;

    logic           clk;
    logic           rst_n;
    logic           cfg_wr_en;
    pdb_pkg::mode_t cfg_wr_data;
    logic           in_valid;
    logic           in_ready;
    argb_t          src_px;
    argb_t          dst_px;
    logic           out_valid;
    logic           out_ready;
    pdb_pkg::pix_t  out_a;
    pdb_pkg::pix_t  out_r;
    pdb_pkg::pix_t  out_g;
    pdb_pkg::pix_t  out_b;

    int mismatches;
    int blends_waiting;
    int words_checked;
    int input_stalls;

    int  pixels_sent = 0;
    bit  steady = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    logic [MODE_CODES-1:0] modes_seen = '0;

    porter_duff_pixel_blend_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .src_a       (src_px.a),
        .src_r       (src_px.r),
        .src_g       (src_px.g),
        .src_b       (src_px.b),
        .dst_a       (dst_px.a),
        .dst_r       (dst_px.r),
        .dst_g       (dst_px.g),
        .dst_b       (dst_px.b),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_a       (out_a),
        .out_r       (out_r),
        .out_g       (out_g),
        .out_b       (out_b)
    );

    pdb_blend_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .src_a          (src_px.a),
        .src_r          (src_px.r),
        .src_g          (src_px.g),
        .src_b          (src_px.b),
        .dst_a          (dst_px.a),
        .dst_r          (dst_px.r),
        .dst_g          (dst_px.g),
        .dst_b          (dst_px.b),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_a          (out_a),
        .out_r          (out_r),
        .out_g          (out_g),
        .out_b          (out_b),
        .mismatches     (mismatches),
        .blends_waiting (blends_waiting),
        .words_checked  (words_checked),
        .input_stalls   (input_stalls)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver: random stalls, one long hold-off, a quiet stretch while steady
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (steady)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 35);
        end
    end

    function automatic void corner_pair(int k, output argb_t s, output argb_t d);
        case (k)
            0: begin s = '0; d = '0; end
            1: begin s = '1; d = '1; end
            2: begin s = '1; d = '0; end
            3: begin s = '0; d = '1; end
            4: begin s = '{8'h00, 8'hFF, 8'hFF, 8'hFF}; d = '{8'h00, 8'hFF, 8'hFF, 8'hFF}; end
            5: begin s = '{8'hFF, 8'h55, 8'hAA, 8'h00}; d = '{8'h80, 8'h7F, 8'h01, 8'h80}; end
            6: begin s = '{8'hAA, 8'hAA, 8'h55, 8'hAA}; d = '{8'h55, 8'h55, 8'hAA, 8'h55}; end
            default: begin s = '{8'h01, 8'h01, 8'h00, 8'h01}; d = '{8'hFE, 8'hFE, 8'hFF, 8'h7F}; end
        endcase
    endfunction

    function automatic argb_t random_pixel();
        argb_t p;
        int kind;
        kind = $urandom_range(0, 99);
        p.a = 8'($urandom_range(0, 255));
        if (kind < 60)
        begin
            p.r = 8'($urandom_range(0, p.a));
            p.g = 8'($urandom_range(0, p.a));
            p.b = 8'($urandom_range(0, p.a));
        end
        else if (kind < 85)
        begin
            p.r = 8'($urandom_range(0, 255));
            p.g = 8'($urandom_range(0, 255));
            p.b = 8'($urandom_range(0, 255));
        end
        else
        begin
            p.a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.g = $urandom_range(0, 1) ? 8'hFF : p.a;
            p.b = 8'($urandom_range(0, 255));
        end
        return p;
    endfunction

    task automatic send_pixels(argb_t s, argb_t d);
        while (!steady && $urandom_range(0, 99) < 35)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        src_px   <= s;
        dst_px   <= d;
        do
            @(posedge clk);
        while (!in_ready);
        pixels_sent++;
        steady   = (pixels_sent >= STEADY_FROM) && (pixels_sent < STEADY_TO);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (blends_waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_mode(pdb_pkg::mode_t m);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        modes_seen[m] = 1'b1;
    endtask

    initial
    begin
        argb_t s;
        argb_t d;
        pdb_pkg::mode_t m;
        int phase;
        int burst;
        int drain;
        int failures;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = pdb_pkg::MODE_SRCOVER;
        in_valid    = 1'b0;
        src_px      = '0;
        dst_px      = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset mode is src-over; exercise it before any write
        modes_seen[pdb_pkg::MODE_SRCOVER] = 1'b1;
        for (int k = 0; k < CORNER_COUNT; k++)
        begin
            corner_pair(k, s, d);
            send_pixels(s, d);
        end

        phase = 0;
        while (pixels_sent < PIXEL_TARGET)
        begin
            m = (phase < MODE_CODES) ? pdb_pkg::mode_t'(phase)
                                     : pdb_pkg::mode_t'($urandom_range(0, MODE_CODES - 1));
            load_mode(m);
            corner_pair($urandom_range(0, CORNER_COUNT - 1), s, d);
            send_pixels(s, d);
            corner_pair($urandom_range(0, CORNER_COUNT - 1), s, d);
            send_pixels(s, d);
            burst = $urandom_range(40, 110);
            // start the long receiver hold-off while a burst is still being offered
            if (pixels_sent >= HOLD_AT)
                hold_req = 1'b1;
            repeat (burst)
                send_pixels(random_pixel(), random_pixel());
            phase++;
        end
        load_mode(pdb_pkg::MODE_SRCOVER);
        repeat (20)
            send_pixels(random_pixel(), random_pixel());

        @(negedge clk);
        in_valid <= 1'b0;
        drain = 0;
        while (blends_waiting != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        failures = mismatches;
        if (blends_waiting != 0)
        begin
            $display("%0t ns: %0d blended words never arrived, expected 0 actual %0d",
                     $time, blends_waiting, blends_waiting);
            failures++;
        end

        $display("Blended %0d pixel pairs, %0d words compared, %0d of %0d mode codes used.",
                 pixels_sent, words_checked, $countones(modes_seen), MODE_CODES);
        $display("Input held off for %0d cycles by output backpressure.", input_stalls);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
